@@ hw/rtl/hxp_pkg.sv @@
// ----------------------------------------------------------------------------
// hxp_pkg
// Shared types and constants for the hex color string parser.
// ----------------------------------------------------------------------------
package hxp_pkg;

    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 32;
    localparam int NIBBLE_W = 4;
    localparam int COUNT_W = 4;
    localparam int SLOTS   = 8;
    localparam int SLOT_W  = $clog2(SLOTS);

    localparam logic [CHAR_W-1:0] CHAR_HASH  = 8'h23;
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LO_F  = 8'h66;
    localparam logic [CHAR_W-1:0] CHAR_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UP_F  = 8'h46;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam int         ALPHA_SHIFT  = 24;

    // character position of the final character for each accepted form
    localparam logic [COUNT_W-1:0] POS_END_RGB      = 4'd3;
    localparam logic [COUNT_W-1:0] POS_END_ARGB     = 4'd4;
    localparam logic [COUNT_W-1:0] POS_END_RRGGBB   = 4'd6;
    localparam logic [COUNT_W-1:0] POS_END_AARRGGBB = 4'd8;
    localparam logic [COUNT_W-1:0] POS_MAX          = 4'd15;

    typedef struct packed {
        logic                is_hash;
        logic                is_dot;
        logic                is_hex;
        logic [NIBBLE_W-1:0] value;
    } t_char_info;

    typedef struct packed {
        logic               bad;
        logic [COLOR_W-1:0] color;
    } t_parse_result;

endpackage

@@ hw/rtl/hxp_stream_if.sv @@
// ----------------------------------------------------------------------------
// hxp_stream_if
// Valid/ready channels for characters in and colors out.
// ----------------------------------------------------------------------------
interface hxp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface hxp_color_if;
    logic        valid;
    logic        ready;
    logic [31:0] color_argb;
    logic        status;

    modport source (output valid, output color_argb, output status, input ready);
    modport sink   (input valid, input color_argb, input status, output ready);
endinterface

@@ hw/rtl/hex_color_string_parser_unit.sv @@
// ----------------------------------------------------------------------------
// hex_color_string_parser_unit
// Parses #rgb / #argb / #rrggbb / #aarrggbb strings one character per
// transaction and emits the stored ARGB color with a status on the last one.
// ----------------------------------------------------------------------------
// Path: the last character's transaction loads the input register, and the
//   result register is loaded from it after one pass of decode/assemble,
//   once the result register is free to take it.
// Throughput: 1 character per cycle; only a stalled result blocks a last character.
// Reset (synchronous, active low): clears the character count, error flag,
//   stored color and both valid flags; digit slots are not cleared.
// ----------------------------------------------------------------------------
module hex_color_string_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hxp_char_if.sink    i_char,
    hxp_color_if.source o_color
);
    import hxp_pkg::*;

    logic                          r_in_valid, n_in_valid;
    logic [CHAR_W-1:0]             r_in_char;
    logic                          r_in_last;

    logic [COUNT_W-1:0]            r_count, n_count;
    logic                          r_bad, n_bad;
    logic [COLOR_W-1:0]            r_color, n_color;
    logic [SLOTS-1:0][NIBBLE_W-1:0] r_digits;
    logic [SLOTS-1:0]              r_keeps;

    logic                          r_out_valid, n_out_valid;
    logic [COLOR_W-1:0]            r_out_color;
    logic                          r_out_status;

    t_char_info                    info;
    t_parse_result                 result;
    logic                          out_free;
    logic                          step;
    logic                          accept;
    logic                          slot_en;
    logic [SLOT_W-1:0]             slot_idx;
    logic                          char_bad;
    logic [SLOTS-1:0][NIBBLE_W-1:0] eff_digits;
    logic [SLOTS-1:0]              eff_keeps;

    hxp_char_dec u_dec (
        .i_char (r_in_char),
        .o_info (info)
    );

    always_comb begin
        out_free = !r_out_valid || o_color.ready;
        step     = r_in_valid && (!r_in_last || out_free);
        accept   = i_char.valid && i_char.ready;
        slot_en  = (r_count != '0) && (r_count <= COUNT_W'(SLOTS));
        slot_idx = SLOT_W'(r_count - 1'b1);

        if (r_count == '0) begin
            char_bad = !info.is_hash;
        end else if (slot_en) begin
            char_bad = !(info.is_hex || info.is_dot);
        end else begin
            char_bad = 1'b0;
        end

        eff_digits = r_digits;
        eff_keeps  = r_keeps;
        if (slot_en) begin
            eff_digits[slot_idx] = info.value;
            eff_keeps[slot_idx]  = info.is_dot;
        end
    end

    hxp_assemble u_asm (
        .i_digits     (eff_digits),
        .i_keeps      (eff_keeps),
        .i_pos        (r_count),
        .i_syntax_bad (r_bad | char_bad),
        .i_old        (r_color),
        .o_result     (result)
    );

    assign i_char.ready      = !r_in_valid || step;
    assign o_color.valid     = r_out_valid;
    assign o_color.color_argb = r_out_color;
    assign o_color.status    = r_out_status;

    always_comb begin
        n_in_valid  = accept ? 1'b1 : (step ? 1'b0 : r_in_valid);
        n_count     = r_count;
        n_bad       = r_bad;
        n_color     = r_color;
        n_out_valid = r_out_valid && !o_color.ready;
        if (step) begin
            if (r_in_last) begin
                n_count     = '0;
                n_bad       = 1'b0;
                n_color     = result.color;
                n_out_valid = 1'b1;
            end else begin
                n_bad = r_bad | char_bad;
                if (r_count != POS_MAX) begin
                    n_count = r_count + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_count     <= '0;
            r_bad       <= 1'b0;
            r_color     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_count     <= n_count;
            r_bad       <= n_bad;
            r_color     <= n_color;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_char <= i_char.char_code;
            r_in_last <= i_char.last_char;
        end
        if (step && slot_en) begin
            r_digits[slot_idx] <= info.value;
            r_keeps[slot_idx]  <= info.is_dot;
        end
        if (step && r_in_last) begin
            r_out_color  <= result.color;
            r_out_status <= result.bad;
        end
    end

    a_out_matches_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_color == r_color)
        else $error("result color differs from stored color");

    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && r_in_last |=> r_count == '0 && !r_bad)
        else $error("string state not cleared after last character");

    a_stall_holds_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_in_last && !out_free |=> r_in_valid && $stable(r_count))
        else $error("last character lost while result stalled");

    a_count_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && !r_in_last && r_count != POS_MAX |=> r_count == $past(r_count) + 1'b1)
        else $error("character count did not advance");

    a_error_keeps_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && r_in_last && result.bad |=> $stable(r_color))
        else $error("malformed string changed stored color");

endmodule

@@ hw/rtl/hxp_char_dec.sv @@
// ----------------------------------------------------------------------------
// hxp_char_dec
// Classifies one character: '#', '.', hex digit and its nibble value.
// ----------------------------------------------------------------------------
module hxp_char_dec (
    input  logic [hxp_pkg::CHAR_W-1:0] i_char,
    output hxp_pkg::t_char_info        o_info
);
    import hxp_pkg::*;

    logic is_num;
    logic is_lo;
    logic is_up;

    always_comb begin
        is_num = (i_char >= CHAR_ZERO) && (i_char <= CHAR_NINE);
        is_lo  = (i_char >= CHAR_LO_A) && (i_char <= CHAR_LO_F);
        is_up  = (i_char >= CHAR_UP_A) && (i_char <= CHAR_UP_F);

        o_info.is_hash = (i_char == CHAR_HASH);
        o_info.is_dot  = (i_char == CHAR_DOT);
        o_info.is_hex  = is_num | is_lo | is_up;
        if (is_num) begin
            o_info.value = NIBBLE_W'(i_char - CHAR_ZERO);
        end else if (is_lo) begin
            o_info.value = NIBBLE_W'(i_char - CHAR_LO_A + 8'd10);
        end else if (is_up) begin
            o_info.value = NIBBLE_W'(i_char - CHAR_UP_A + 8'd10);
        end else begin
            o_info.value = '0;
        end
    end

endmodule

@@ hw/rtl/hxp_assemble.sv @@
// ----------------------------------------------------------------------------
// hxp_assemble
// Builds the new ARGB color from the digit slots for the string's form.
// ----------------------------------------------------------------------------
module hxp_assemble (
    input  logic [hxp_pkg::SLOTS-1:0][hxp_pkg::NIBBLE_W-1:0] i_digits,
    input  logic [hxp_pkg::SLOTS-1:0]                        i_keeps,
    input  logic [hxp_pkg::COUNT_W-1:0]                      i_pos,
    input  logic                                             i_syntax_bad,
    input  logic [hxp_pkg::COLOR_W-1:0]                      i_old,
    output hxp_pkg::t_parse_result                           o_result
);
    import hxp_pkg::*;

    logic [7:0] old_a, old_r, old_g, old_b;
    logic [7:0] na, nr, ng, nb;
    logic       bad;

    function automatic logic [7:0] single_chan(input logic keep, input logic [3:0] d,
                                               input logic [7:0] orig);
        return keep ? orig : {d, d};
    endfunction

    function automatic logic [7:0] pair_chan(input logic k0, input logic k1,
                                             input logic [3:0] d0, input logic [3:0] d1,
                                             input logic [7:0] orig);
        return (k0 && k1) ? orig : {d0, d1};
    endfunction

    function automatic logic pair_mixed(input logic k0, input logic k1);
        return k0 ^ k1;
    endfunction

    always_comb begin
        old_a = i_old[ALPHA_SHIFT +: 8];
        old_r = i_old[23:16];
        old_g = i_old[15:8];
        old_b = i_old[7:0];
        na = '0;
        nr = '0;
        ng = '0;
        nb = '0;
        bad = i_syntax_bad;
        unique case (i_pos)
            POS_END_RGB: begin
                na = ALPHA_OPAQUE;
                nr = single_chan(i_keeps[0], i_digits[0], old_r);
                ng = single_chan(i_keeps[1], i_digits[1], old_g);
                nb = single_chan(i_keeps[2], i_digits[2], old_b);
            end
            POS_END_ARGB: begin
                na = single_chan(i_keeps[0], i_digits[0], old_a);
                nr = single_chan(i_keeps[1], i_digits[1], old_r);
                ng = single_chan(i_keeps[2], i_digits[2], old_g);
                nb = single_chan(i_keeps[3], i_digits[3], old_b);
            end
            POS_END_RRGGBB: begin
                na = ALPHA_OPAQUE;
                nr = pair_chan(i_keeps[0], i_keeps[1], i_digits[0], i_digits[1], old_r);
                ng = pair_chan(i_keeps[2], i_keeps[3], i_digits[2], i_digits[3], old_g);
                nb = pair_chan(i_keeps[4], i_keeps[5], i_digits[4], i_digits[5], old_b);
                bad = bad | pair_mixed(i_keeps[0], i_keeps[1])
                          | pair_mixed(i_keeps[2], i_keeps[3])
                          | pair_mixed(i_keeps[4], i_keeps[5]);
            end
            POS_END_AARRGGBB: begin
                na = pair_chan(i_keeps[0], i_keeps[1], i_digits[0], i_digits[1], old_a);
                nr = pair_chan(i_keeps[2], i_keeps[3], i_digits[2], i_digits[3], old_r);
                ng = pair_chan(i_keeps[4], i_keeps[5], i_digits[4], i_digits[5], old_g);
                nb = pair_chan(i_keeps[6], i_keeps[7], i_digits[6], i_digits[7], old_b);
                bad = bad | pair_mixed(i_keeps[0], i_keeps[1])
                          | pair_mixed(i_keeps[2], i_keeps[3])
                          | pair_mixed(i_keeps[4], i_keeps[5])
                          | pair_mixed(i_keeps[6], i_keeps[7]);
            end
            default: begin
                bad = 1'b1;
            end
        endcase
        o_result.bad   = bad;
        o_result.color = bad ? i_old : {na, nr, ng, nb};
    end

endmodule

@@ bench/tb_hex_color_string_parser_unit.sv @@
// ----------------------------------------------------------------------------
// tb_hex_color_string_parser_unit
// Streams color strings into the parser one character per transaction and
// compares each emitted color and status against a cycle-free model of the
// parse kept in a small scoreboard. Directed strings cover every form, the
// keep markers, mixed pairs, bad characters, a missing '#', wrong and
// saturating lengths; random strings follow, mostly well formed. Both sides
// stall at random, with quiet stretches, and the sender drains now and then.
// ----------------------------------------------------------------------------
module tb_hex_color_string_parser_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import hxp_pkg::*;

    typedef logic [CHAR_W-1:0] t_char;

    localparam int RANDOM_CHARS = 840;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int TAIL_CYCLES  = 8;

    class color_scoreboard;
        logic [COUNT_W-1:0]  char_pos;
        logic [NIBBLE_W-1:0] digits [SLOTS];
        logic                marks  [SLOTS];
        logic                flagged;
        logic [COLOR_W-1:0]  held_color;
        t_parse_result       pending_colors [$];
        int                  errors;
        int                  checked;
        int                  malformed;

        function new();
            char_pos   = '0;
            flagged    = 1'b0;
            held_color = '0;
            foreach (digits[i]) begin
                digits[i] = '0;
                marks[i]  = 1'b0;
            end
            errors    = 0;
            checked   = 0;
            malformed = 0;
        endfunction

        function bit hex_nibble(input t_char c, output logic [NIBBLE_W-1:0] v);
            v = '0;
            hex_nibble = 1'b1;
            if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                v = NIBBLE_W'(c - CHAR_ZERO);
            end else if (c >= CHAR_LO_A && c <= CHAR_LO_F) begin
                v = NIBBLE_W'(c - CHAR_LO_A + 8'd10);
            end else if (c >= CHAR_UP_A && c <= CHAR_UP_F) begin
                v = NIBBLE_W'(c - CHAR_UP_A + 8'd10);
            end else begin
                hex_nibble = 1'b0;
            end
        endfunction

        function logic [7:0] one_digit(input int i, input logic [7:0] orig);
            return marks[i] ? orig : {digits[i], digits[i]};
        endfunction

        function logic [7:0] two_digit(input int i, input logic [7:0] orig, inout logic bad);
            if (marks[i] && marks[i+1]) return orig;
            if (marks[i] || marks[i+1]) begin
                bad = 1'b1;
                return 8'h00;
            end
            return {digits[i], digits[i+1]};
        endfunction

        function void note_char(input t_char c, input logic last);
            logic [COUNT_W-1:0]  pos;
            logic [NIBBLE_W-1:0] v;
            logic                ok;
            logic                bad;
            logic [7:0]          old_a, old_r, old_g, old_b;
            logic [7:0]          na, nr, ng, nb;
            t_parse_result       want;
            pos = char_pos;
            ok  = hex_nibble(c, v);
            if (pos == '0) begin
                if (c != CHAR_HASH) flagged = 1'b1;
            end else if (pos <= POS_END_AARRGGBB) begin
                digits[pos-1] = v;
                marks[pos-1]  = (c == CHAR_DOT);
                if (!ok && c != CHAR_DOT) flagged = 1'b1;
            end
            if (pos != POS_MAX) char_pos = pos + 1'b1;
            if (!last) return;

            bad = flagged;
            {old_a, old_r, old_g, old_b} = held_color;
            {na, nr, ng, nb} = '0;
            case (pos)
                POS_END_RGB: begin
                    na = ALPHA_OPAQUE;
                    nr = one_digit(0, old_r);
                    ng = one_digit(1, old_g);
                    nb = one_digit(2, old_b);
                end
                POS_END_ARGB: begin
                    na = one_digit(0, old_a);
                    nr = one_digit(1, old_r);
                    ng = one_digit(2, old_g);
                    nb = one_digit(3, old_b);
                end
                POS_END_RRGGBB: begin
                    na = ALPHA_OPAQUE;
                    nr = two_digit(0, old_r, bad);
                    ng = two_digit(2, old_g, bad);
                    nb = two_digit(4, old_b, bad);
                end
                POS_END_AARRGGBB: begin
                    na = two_digit(0, old_a, bad);
                    nr = two_digit(2, old_r, bad);
                    ng = two_digit(4, old_g, bad);
                    nb = two_digit(6, old_b, bad);
                end
                default: bad = 1'b1;
            endcase
            if (!bad) held_color = {na, nr, ng, nb};
            want.bad   = bad;
            want.color = held_color;
            pending_colors.push_back(want);
            char_pos = '0;
            flagged  = 1'b0;
        endfunction

        task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
            errors++;
            $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        endtask

        task check_color(input logic [COLOR_W-1:0] color, input logic status);
            t_parse_result want;
            if (pending_colors.size() == 0) begin
                report_mismatch("unexpected color transaction", color, '0);
                return;
            end
            want = pending_colors.pop_front();
            checked++;
            if (want.bad) malformed++;
            if (color !== want.color) report_mismatch("color_argb", color, want.color);
            if (status !== want.bad) report_mismatch("status", 32'(status), 32'(want.bad));
        endtask

        function int pending();
            return pending_colors.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    hxp_char_if  char_bus ();
    hxp_color_if color_bus ();

    hex_color_string_parser_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_bus),
        .o_color (color_bus)
    );

    color_scoreboard sb = new();
    bit    calm;
    t_char text [$];
    int    chars_sent;
    int    strings_sent;
    int    cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("TB_ERROR");
        $finish;
    end

    task automatic send_char(input t_char c, input logic last);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            char_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        char_bus.valid     <= 1'b1;
        char_bus.char_code <= c;
        char_bus.last_char <= last;
        do @(posedge i_clk); while (!(char_bus.valid && char_bus.ready));
        sb.note_char(c, last);
        chars_sent++;
    endtask

    task automatic send_text();
        for (int i = 0; i < text.size(); i++) send_char(text[i], i == text.size() - 1);
        strings_sent++;
    endtask

    task automatic send_literal(input string s);
        text.delete();
        for (int i = 0; i < s.len(); i++) text.push_back(t_char'(s[i]));
        send_text();
    endtask

    task automatic drain_colors();
        char_bus.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() > 0);
    endtask

    function automatic t_char rand_hex();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10) return CHAR_ZERO + t_char'(v);
        return ($urandom_range(0, 1) ? CHAR_LO_A : CHAR_UP_A) + t_char'(v - 10);
    endfunction

    task automatic build_wellformed();
        int form;
        int k;
        text.delete();
        text.push_back(CHAR_HASH);
        form = $urandom_range(0, 3);
        if (form < 2) begin
            repeat (form == 0 ? 3 : 4)
                text.push_back($urandom_range(0, 5) == 0 ? CHAR_DOT : rand_hex());
        end else begin
            repeat (form == 2 ? 3 : 4) begin
                k = $urandom_range(0, 9);
                if (k == 0) begin
                    text.push_back(CHAR_DOT);
                    text.push_back(CHAR_DOT);
                end else if (k == 1) begin
                    if ($urandom_range(0, 1)) begin
                        text.push_back(CHAR_DOT);
                        text.push_back(rand_hex());
                    end else begin
                        text.push_back(rand_hex());
                        text.push_back(CHAR_DOT);
                    end
                end else begin
                    text.push_back(rand_hex());
                    text.push_back(rand_hex());
                end
            end
        end
    endtask

    task automatic build_broken();
        int len;
        text.delete();
        len = $urandom_range(1, 20);
        text.push_back($urandom_range(0, 9) < 7 ? CHAR_HASH : t_char'($urandom_range(0, 255)));
        for (int i = 1; i < len; i++) begin
            case ($urandom_range(0, 3))
                0, 1:    text.push_back(rand_hex());
                2:       text.push_back(CHAR_DOT);
                default: text.push_back(t_char'($urandom_range(0, 255)));
            endcase
        end
    endtask

    // result side
    initial begin
        int stall;
        color_bus.ready <= 1'b0;
        repeat (10) @(posedge i_clk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                color_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            color_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!(color_bus.valid && color_bus.ready));
            sb.check_color(color_bus.color_argb, color_bus.status);
        end
    end

    initial begin
        int start_chars;
        calm         = 1'b0;
        chars_sent   = 0;
        strings_sent = 0;
        i_rst_n            <= 1'b0;
        char_bus.valid     <= 1'b0;
        char_bus.char_code <= '0;
        char_bus.last_char <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_literal("#fff");
        send_literal("#0000");
        send_literal("#FFFFFFFF");
        send_literal("#a1B2c3");
        send_literal("#.0.");
        send_literal("#....");
        send_literal("#..5E..");
        send_literal("#.1aabbcc");
        send_literal("x1234");
        send_literal("#12g");
        send_literal("##12");
        send_literal("#12");
        send_literal("#");
        send_literal("#1234567");
        send_literal("#0123456789abcdef0123");
        text = '{CHAR_HASH, 8'h00, 8'hFF, 8'h80};
        send_text();
        calm = 1'b1;
        send_literal("#00000000");
        calm = 1'b0;
        drain_colors();

        start_chars = chars_sent;
        while (chars_sent - start_chars < RANDOM_CHARS) begin
            if ($urandom_range(0, 15) == 0) calm = !calm;
            if ($urandom_range(0, 9) < 7) build_wellformed();
            else build_broken();
            send_text();
            if ($urandom_range(0, 39) == 0) drain_colors();
        end
        calm = 1'b0;

        drain_colors();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("sent %0d characters in %0d strings over %0d cycles",
                 chars_sent, strings_sent, cycle_count);
        $display("checked %0d colors, %0d of them flagged malformed", sb.checked, sb.malformed);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
